// ===== rtl/spq_pkg.sv =====
package spq_pkg;

	localparam int CAPACITY   = 16;
	localparam int VALUE_BITS = 32;
	localparam int POS_W      = $clog2(CAPACITY);
	localparam int CNT_W      = $clog2(CAPACITY + 1);
	localparam int CMD_W      = 2;

	typedef logic signed [VALUE_BITS-1:0] value_t;
	typedef logic [POS_W-1:0] pos_t;
	typedef logic [CNT_W-1:0] cnt_t;

	typedef enum logic [CMD_W-1:0] {
		CMD_INSERT = 2'd0,
		CMD_REMOVE = 2'd1,
		CMD_FIND   = 2'd2
	} cmd_t;

	// per-cycle command broadcast to every cell
	typedef struct packed {
		logic ins;
		logic rem;
	} cell_ctrl_t;

	// compare result each cell reports back
	typedef struct packed {
		logic gt;
		logic eq;
	} cell_stat_t;

endpackage

// ===== rtl/spq_req_if.sv =====
interface spq_req_if;
	logic                                 valid;
	logic                                 ready;
	logic [spq_pkg::CMD_W-1:0]            cmd;
	logic signed [spq_pkg::VALUE_BITS-1:0] value;

	modport source (output valid, output cmd, output value, input ready);
	modport sink (input valid, input cmd, input value, output ready);
endinterface

// ===== rtl/spq_rsp_if.sv =====
interface spq_rsp_if;
	logic                                  valid;
	logic                                  ready;
	logic                                  ok;
	logic                                  full_drop;
	logic [spq_pkg::POS_W-1:0]             position;
	logic [spq_pkg::CNT_W-1:0]             entry_count;
	logic                                  head_valid;
	logic signed [spq_pkg::VALUE_BITS-1:0] head_value;

	modport source (output valid, output ok, output full_drop, output position,
		output entry_count, output head_valid, output head_value, input ready);
	modport sink (input valid, input ok, input full_drop, input position,
		input entry_count, input head_valid, input head_value, output ready);
endinterface

// ===== rtl/spq_cell.sv =====
module spq_cell (
	input  logic                clk,
	input  spq_pkg::cell_ctrl_t ctrl,
	input  logic                in_use,
	input  logic                left_gt,
	input  spq_pkg::value_t     v,
	input  spq_pkg::value_t     left_val,
	input  spq_pkg::value_t     right_val,
	output spq_pkg::value_t     val,
	output spq_pkg::cell_stat_t stat
);

	spq_pkg::value_t val_q;

	assign stat.gt = in_use && (val_q > v);
	assign stat.eq = in_use && (val_q == v);
	assign val     = val_q;

	always_ff @(posedge clk) begin
		if (ctrl.ins && !stat.gt) begin
			// first cell not greater takes the new value, the rest move down
			val_q <= left_gt ? v : left_val;
		end else if (ctrl.rem && !stat.gt) begin
			val_q <= right_val;
		end
	end

endmodule

// ===== rtl/sorted_priority_queue.sv =====
// channel | dir | fields
// req     | in  | cmd, value
// rsp     | out | ok, full_drop, position, entry_count, head_valid, head_value
//
// one request per cycle while req.ready is high: all cells compare against the value at once and
// shift in the same cycle, and the response lands in a register at that same clock edge.
// req.ready is high while the response register is empty or being taken.
// reset clears the entry count and the response valid; cell contents are
// only read below the entry count.
module sorted_priority_queue (
	input logic      clk,
	input logic      arst_n,
	spq_req_if.sink  req,
	spq_rsp_if.source rsp
);

	localparam int N = spq_pkg::CAPACITY;

	spq_pkg::cnt_t       count_q;
	logic                rsp_valid_q;
	logic                ok_q;
	logic                drop_q;
	spq_pkg::pos_t       pos_q;
	spq_pkg::cnt_t       cnt_out_q;
	spq_pkg::value_t     head_q;

	spq_pkg::value_t     v;
	spq_pkg::value_t     vals   [N];
	spq_pkg::cell_stat_t stats  [N];
	logic                left_gt[N];
	logic                hit    [N];
	spq_pkg::cell_ctrl_t ctrl;

	logic                accept;
	logic                is_ins;
	logic                is_rem;
	logic                is_find;
	logic                full;
	logic                found;
	spq_pkg::pos_t       hit_pos;
	spq_pkg::cnt_t       count_d;
	spq_pkg::value_t     head_d;
	logic                ok_d;

	assign v       = req.value;
	assign accept  = req.valid && req.ready;
	assign is_ins  = (req.cmd == spq_pkg::CMD_INSERT);
	assign is_rem  = (req.cmd == spq_pkg::CMD_REMOVE);
	assign is_find = (req.cmd == spq_pkg::CMD_FIND);
	assign full    = (count_q == spq_pkg::CNT_W'(N));

	assign req.ready = !rsp_valid_q || rsp.ready;

	assign ctrl.ins = accept && is_ins && !full;
	assign ctrl.rem = accept && is_rem && found;

	genvar g;
	generate
		for (g = 0; g < N; g++) begin : g_cell
			spq_pkg::value_t lv;
			spq_pkg::value_t rv;
			logic            use_c;

			if (g == 0) begin : g_first
				assign left_gt[g] = 1'b1;
				assign lv         = v;
			end else begin : g_mid
				assign left_gt[g] = stats[g-1].gt;
				assign lv         = vals[g-1];
			end
			if (g == N - 1) begin : g_last
				assign rv = vals[g];
			end else begin : g_inner
				assign rv = vals[g+1];
			end

			assign use_c  = (spq_pkg::CNT_W'(g) < count_q);
			// boundary cell: left neighbor greater, this one not, and equal to the value
			assign hit[g] = left_gt[g] && !stats[g].gt && stats[g].eq;

			spq_cell u_cell (
				.clk       (clk),
				.ctrl      (ctrl),
				.in_use    (use_c),
				.left_gt   (left_gt[g]),
				.v         (v),
				.left_val  (lv),
				.right_val (rv),
				.val       (vals[g]),
				.stat      (stats[g])
			);
		end
	endgenerate

	always_comb begin
		found   = 1'b0;
		hit_pos = '0;
		for (int j = 0; j < N; j++) begin
			if (hit[j]) begin
				found   = 1'b1;
				hit_pos = spq_pkg::POS_W'(j);
			end
		end
	end

	always_comb begin
		count_d = count_q;
		head_d  = vals[0];
		ok_d    = 1'b0;
		if (ctrl.ins) begin
			count_d = count_q + 1'b1;
			ok_d    = 1'b1;
			if (!stats[0].gt) begin
				head_d = v;
			end
		end else if (ctrl.rem) begin
			count_d = count_q - 1'b1;
			ok_d    = 1'b1;
			if (hit[0]) begin
				head_d = vals[1];
			end
		end else if (is_find) begin
			ok_d = found;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				count_q     <= count_d;
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ok_q      <= ok_d;
			drop_q    <= is_ins && full;
			pos_q     <= (ok_d && !is_ins) ? hit_pos : '0;
			cnt_out_q <= count_d;
			head_q    <= (count_d == '0) ? '0 : head_d;
		end
	end

	assign rsp.valid       = rsp_valid_q;
	assign rsp.ok          = ok_q;
	assign rsp.full_drop   = drop_q;
	assign rsp.position    = pos_q;
	assign rsp.entry_count = cnt_out_q;
	assign rsp.head_valid  = (cnt_out_q != '0);
	assign rsp.head_value  = head_q;

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= spq_pkg::CNT_W'(N))
		else $error("entry count above capacity");

	a_insert_grows: assert property (@(posedge clk) disable iff (!arst_n)
		accept && is_ins && !full |=> count_q == $past(count_q) + 1'b1)
		else $error("insert did not add an entry");

	a_drop_not_ok: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && drop_q |-> !ok_q && cnt_out_q == spq_pkg::CNT_W'(N))
		else $error("dropped insert with wrong status");

	a_miss_keeps: assert property (@(posedge clk) disable iff (!arst_n)
		accept && !is_ins && !found |=> count_q == $past(count_q))
		else $error("entry count changed without a match");

endmodule

// ===== tb/sv/sorted_priority_queue_test.sv =====
`timescale 1ns / 1ps

module sorted_priority_queue_test;

	localparam logic [spq_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;
	localparam int ITEMS_PER_PHASE = 500;
	localparam int STALL_LIMIT     = 2000;
	localparam int MAX_REPORTS     = 10;
	localparam int TAIL_CYCLES     = 10;

	typedef struct packed {
		logic            ok;
		logic            full_drop;
		spq_pkg::pos_t   position;
		spq_pkg::cnt_t   entry_count;
		logic            head_valid;
		spq_pkg::value_t head_value;
	} rsp_t;

	typedef enum int {SEQ_FILL, SEQ_DRAIN, SEQ_MIXED, SEQ_NOISE} seq_mode_t;

	// mirror of the descending store plus the responses still owed by the block
	class sorted_store_tracker;
		spq_pkg::value_t store[spq_pkg::CAPACITY];
		int              count;
		rsp_t            pending_responses[$];
		int              mismatches;

		function new();
			count      = 0;
			mismatches = 0;
		endfunction

		function void apply_request(logic [spq_pkg::CMD_W-1:0] cmd, spq_pkg::value_t v);
			rsp_t r;
			int   i;
			r = '0;
			i = 0;
			// first entry not greater than v
			while (i < count && store[i] > v)
				i++;
			case (cmd)
				spq_pkg::CMD_INSERT: begin
					if (count >= spq_pkg::CAPACITY) begin
						r.full_drop = 1'b1;
					end else begin
						for (int j = count; j > i; j--)
							store[j] = store[j-1];
						store[i] = v;
						count++;
						r.ok = 1'b1;
					end
				end
				spq_pkg::CMD_REMOVE: begin
					if (i < count && store[i] == v) begin
						for (int j = i; j + 1 < count; j++)
							store[j] = store[j+1];
						count--;
						r.ok       = 1'b1;
						r.position = spq_pkg::pos_t'(i);
					end
				end
				spq_pkg::CMD_FIND: begin
					if (i < count && store[i] == v) begin
						r.ok       = 1'b1;
						r.position = spq_pkg::pos_t'(i);
					end
				end
				default: ;
			endcase
			r.entry_count = spq_pkg::cnt_t'(count);
			r.head_valid  = (count > 0);
			r.head_value  = (count > 0) ? store[0] : '0;
			pending_responses.push_back(r);
		endfunction

		function spq_pkg::value_t pick_stored();
			return store[$urandom_range(count - 1)];
		endfunction

		function void check_response(rsp_t got);
			rsp_t want;
			if (pending_responses.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("unexpected response: ok=%0b drop=%0b pos=%0d cnt=%0d hv=%0b head=%0d",
						got.ok, got.full_drop, got.position, got.entry_count,
						got.head_valid, got.head_value);
				return;
			end
			want = pending_responses.pop_front();
			if (got.ok !== want.ok || got.full_drop !== want.full_drop ||
					got.position !== want.position || got.entry_count !== want.entry_count ||
					got.head_valid !== want.head_valid || got.head_value !== want.head_value) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS) begin
					$display("response mismatch at %0t", $realtime);
					$display("  expected ok=%0b drop=%0b pos=%0d cnt=%0d hv=%0b head=%0d",
						want.ok, want.full_drop, want.position, want.entry_count,
						want.head_valid, want.head_value);
					$display("  actual   ok=%0b drop=%0b pos=%0d cnt=%0d hv=%0b head=%0d",
						got.ok, got.full_drop, got.position, got.entry_count,
						got.head_valid, got.head_value);
				end
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;

	spq_req_if req_ch();
	spq_rsp_if rsp_ch();

	sorted_priority_queue u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	sorted_store_tracker tracker;
	int send_idle_pct;
	int recv_stall_pct;
	int stall_cycles;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic spq_pkg::value_t random_value();
		int roll;
		roll = $urandom_range(9);
		if (roll < 4)
			return spq_pkg::value_t'($urandom_range(8)) - spq_pkg::value_t'(4);
		if (roll == 4) begin
			case ($urandom_range(3))
				0: return spq_pkg::value_t'(32'h7fff_ffff);
				1: return spq_pkg::value_t'(32'h8000_0000);
				2: return '1;
				default: return '0;
			endcase
		end
		return spq_pkg::value_t'($urandom);
	endfunction

	// operand that hits a stored entry with the given chance
	function automatic spq_pkg::value_t pick_operand(int hit_pct);
		if (tracker.count > 0 && $urandom_range(99) < hit_pct)
			return tracker.pick_stored();
		return random_value();
	endfunction

	task automatic next_request(input seq_mode_t mode,
			output logic [spq_pkg::CMD_W-1:0] cmd, output spq_pkg::value_t value);
		int roll;
		roll = $urandom_range(99);
		case (mode)
			SEQ_FILL: begin
				if (roll < 85) begin
					cmd   = spq_pkg::CMD_INSERT;
					value = random_value();
				end else begin
					cmd   = spq_pkg::CMD_FIND;
					value = pick_operand(70);
				end
			end
			SEQ_DRAIN: begin
				if (roll < 80) begin
					cmd   = spq_pkg::CMD_REMOVE;
					value = pick_operand(90);
				end else begin
					cmd   = spq_pkg::CMD_FIND;
					value = pick_operand(50);
				end
			end
			SEQ_MIXED: begin
				cmd   = spq_pkg::CMD_W'($urandom_range(2));
				value = (cmd == spq_pkg::CMD_INSERT) ? random_value() : pick_operand(60);
			end
			default: begin
				cmd   = spq_pkg::CMD_W'($urandom_range(3));
				value = spq_pkg::value_t'($urandom);
			end
		endcase
	endtask

	// entered and left at a falling edge
	task automatic send_request(input logic [spq_pkg::CMD_W-1:0] cmd,
			input spq_pkg::value_t value);
		while ($urandom_range(99) < send_idle_pct) begin
			req_ch.valid <= 1'b0;
			@(negedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.cmd   <= cmd;
		req_ch.value <= value;
		do
			@(posedge clk);
		while (!req_ch.ready);
		tracker.apply_request(cmd, value);
		@(negedge clk);
	endtask

	task automatic wait_for_responses();
		req_ch.valid <= 1'b0;
		while (tracker.pending_responses.size() != 0)
			@(negedge clk);
	endtask

	initial begin
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			rsp_t got;
			got.ok          = rsp_ch.ok;
			got.full_drop   = rsp_ch.full_drop;
			got.position    = rsp_ch.position;
			got.entry_count = rsp_ch.entry_count;
			got.head_valid  = rsp_ch.head_valid;
			got.head_value  = rsp_ch.head_value;
			tracker.check_response(got);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
				stall_cycles <= 0;
			else
				stall_cycles <= stall_cycles + 1;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("Mismatches found");
				$finish;
			end
		end
	end

	initial begin
		int                        sent;
		int                        seg;
		seq_mode_t                 mode;
		logic [spq_pkg::CMD_W-1:0] cmd;
		spq_pkg::value_t           value;
		int                        roll;

		tracker        = new();
		stall_cycles   = 0;
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		arst_n         = 1'b0;
		req_ch.valid   = 1'b0;
		req_ch.cmd     = '0;
		req_ch.value   = '0;
		rsp_ch.ready   = 1'b0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// empty store, unused command, extremes and equal values
		send_request(CMD_UNUSED, spq_pkg::value_t'(32'h5a5a_a5a5));
		send_request(spq_pkg::CMD_FIND, '0);
		send_request(spq_pkg::CMD_INSERT, '0);
		send_request(spq_pkg::CMD_INSERT, spq_pkg::value_t'(32'h7fff_ffff));
		send_request(spq_pkg::CMD_INSERT, spq_pkg::value_t'(32'h8000_0000));
		send_request(spq_pkg::CMD_INSERT, '0);
		send_request(spq_pkg::CMD_FIND, '0);
		send_request(spq_pkg::CMD_REMOVE, '0);
		send_request(spq_pkg::CMD_REMOVE, spq_pkg::value_t'(32'h7fff_ffff));
		send_request(spq_pkg::CMD_FIND, spq_pkg::value_t'(32'h7fff_ffff));
		send_request(CMD_UNUSED, '1);
		// fill to capacity, then overflow and touch the tail entry
		for (int k = 0; k < spq_pkg::CAPACITY - 2; k++)
			send_request(spq_pkg::CMD_INSERT, spq_pkg::value_t'($urandom));
		send_request(spq_pkg::CMD_INSERT, '1);
		send_request(spq_pkg::CMD_FIND, spq_pkg::value_t'(32'h8000_0000));
		send_request(spq_pkg::CMD_REMOVE, spq_pkg::value_t'(32'h8000_0000));
		wait_for_responses();

		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 55; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 55; end
				default: begin send_idle_pct = 35; recv_stall_pct = 35; end
			endcase
			sent = 0;
			while (sent < ITEMS_PER_PHASE) begin
				roll = $urandom_range(9);
				if (roll < 3)
					mode = SEQ_FILL;
				else if (roll < 6)
					mode = SEQ_DRAIN;
				else if (roll < 9)
					mode = SEQ_MIXED;
				else
					mode = SEQ_NOISE;
				seg = $urandom_range(4, 40);
				repeat (seg) begin
					next_request(mode, cmd, value);
					send_request(cmd, value);
					if (cmd != CMD_UNUSED)
						sent++;
				end
			end
			// hold off the sender until the block has answered everything
			wait_for_responses();
		end

		repeat (TAIL_CYCLES) @(negedge clk);
		if (tracker.mismatches == 0 && tracker.pending_responses.size() == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
